// File: hw/rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants for the clipped line rasterizer
// Register indexes, command codes and the pixel record held in the output
// buffer.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int OUT_BITS       = 12;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 13;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_VIEWPORT_X = 3'd0;
    localparam t_cfg_idx CFG_VIEWPORT_Y = 3'd1;
    localparam t_cfg_idx CFG_VIEWPORT_W = 3'd2;
    localparam t_cfg_idx CFG_VIEWPORT_H = 3'd3;
    localparam t_cfg_idx CFG_WINDOW_W   = 3'd4;
    localparam t_cfg_idx CFG_WINDOW_H   = 3'd5;
    localparam t_cfg_idx CFG_PIXEL_MODE = 3'd6;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam logic [12:0] SIZE_RESET = 13'd4096;

    typedef struct packed {
        logic [OUT_BITS-1:0] x;
        logic [OUT_BITS-1:0] y;
        logic                vis;
        logic                last;
    } t_pix;

endpackage

// File: hw/rtl/lrc_in_if.sv
// ----------------------------------------------------------------------------
// lrc_in_if: command channel of the line rasterizer
// Carries load and step commands with the two line endpoints.
// ----------------------------------------------------------------------------
interface lrc_in_if #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: hw/rtl/lrc_out_if.sv
// ----------------------------------------------------------------------------
// lrc_out_if: pixel channel of the line rasterizer
// Carries one plotted pixel with its visible and last flags.
// ----------------------------------------------------------------------------
interface lrc_out_if;
    logic                        valid;
    logic                        ready;
    logic [lrc_pkg::OUT_BITS-1:0] pixel_x;
    logic [lrc_pkg::OUT_BITS-1:0] pixel_y;
    logic                        visible;
    logic                        last_pixel;

    modport source (output valid, pixel_x, pixel_y, visible, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, visible, last_pixel, output ready);
endinterface

// File: hw/rtl/line_rasterizer_clipped_top.sv
// ----------------------------------------------------------------------------
// line_rasterizer_clipped_top: clipped Bresenham line rasterizer
// Maps endpoints into the viewport, sets up the line and emits one pixel per
// step command on a line in progress, with window and viewport clipping flags.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries commands. A load (mode 0) maps both endpoints, sets up the
//   line and produces nothing. A step (mode 1) emits the current pixel on
//   o_pix and advances one unit along the major axis; a step with no line
//   in progress is dropped. A load replaces any line in progress.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must do so only while the block is idle, which it does not enforce.
// Timing:
//   One command per cycle while i_cmd.ready is high. Each command updates the
//   line state at its transfer edge; a step also queues its pixel for o_pix.
//   A load directly followed by a step runs without a gap.
// Reset and stall:
//   Reset clears the line state, empties the output buffer and restores the
//   register defaults. Pixels wait in a two-entry output buffer; i_cmd.ready
//   drops only while both entries are full.
// ----------------------------------------------------------------------------
module line_rasterizer_clipped_top #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  lrc_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [lrc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    lrc_in_if.sink                          i_cmd,
    lrc_out_if.source                       o_pix
);
    import lrc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int PW   = CB + 14;   // mapped positions
    localparam int EW   = PW + 2;    // error term
    localparam int MULW = CB + 15;   // mapping product and sum

    // configuration registers
    logic [11:0] r_vp_x, r_vp_y;
    logic [12:0] r_vp_w, r_vp_h, r_win_w, r_win_h;
    logic        r_pix_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_x     <= '0;
            r_vp_y     <= '0;
            r_vp_w     <= SIZE_RESET;
            r_vp_h     <= SIZE_RESET;
            r_win_w    <= SIZE_RESET;
            r_win_h    <= SIZE_RESET;
            r_pix_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIEWPORT_X: r_vp_x     <= i_cfg_data[11:0];
                CFG_VIEWPORT_Y: r_vp_y     <= i_cfg_data[11:0];
                CFG_VIEWPORT_W: r_vp_w     <= i_cfg_data;
                CFG_VIEWPORT_H: r_vp_h     <= i_cfg_data;
                CFG_WINDOW_W:   r_win_w    <= i_cfg_data;
                CFG_WINDOW_H:   r_win_h    <= i_cfg_data;
                CFG_PIXEL_MODE: r_pix_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pixel mode: c + origin; normalized: trunc(((c+1)*size + 2*origin) / 2)
    function automatic logic signed [PW-1:0] map_coord(
        input logic signed [CB-1:0] c,
        input logic [12:0]          size,
        input logic [11:0]          origin,
        input logic                 pix
    );
        logic signed [CB:0]     c1;
        logic signed [13:0]     sz;
        logic signed [MULW-1:0] prod;
        logic signed [MULW-1:0] sum;
        logic signed [MULW-1:0] rnd;
        logic signed [MULW-1:0] half;
        logic signed [PW-1:0]   pm;
        c1   = {c[CB-1], c} + (CB+1)'(1);
        sz   = {1'b0, size};
        prod = MULW'(c1) * MULW'(sz);
        sum  = prod + $signed({{(CB+2){1'b0}}, origin, 1'b0});
        // round a negative odd value toward zero before the shift
        rnd  = sum + MULW'(sum[MULW-1]);
        half = rnd >>> 1;
        pm   = {{(PW-CB){c[CB-1]}}, c} + $signed({{(PW-12){1'b0}}, origin});
        return pix ? pm : half[PW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] abs_diff(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // line state
    logic signed [PW-1:0] r_major, r_minor, r_major_end;
    logic [PW-2:0]        r_dmaj, r_dmin;
    logic signed [EW-1:0] r_err;
    logic                 r_swap, r_up, r_active;

    logic signed [PW-1:0] w_x1, w_y1, w_x2, w_y2, w_dx, w_dy;
    logic signed [PW-1:0] w_a1, w_b1, w_a2, w_b2;
    logic signed [PW-1:0] n_major, n_minor, n_major_end, w_dmaj, w_dmin;
    logic                 w_steep, w_order, n_up;

    always_comb begin
        w_x1 = map_coord(i_cmd.start_x, r_vp_w, r_vp_x, r_pix_mode);
        w_y1 = map_coord(i_cmd.start_y, r_vp_h, r_vp_y, r_pix_mode);
        w_x2 = map_coord(i_cmd.end_x,   r_vp_w, r_vp_x, r_pix_mode);
        w_y2 = map_coord(i_cmd.end_y,   r_vp_h, r_vp_y, r_pix_mode);
        w_dx = abs_diff(w_x2, w_x1);
        w_dy = abs_diff(w_y2, w_y1);
        w_steep = w_dy > w_dx;
        w_a1 = w_steep ? w_y1 : w_x1;
        w_b1 = w_steep ? w_x1 : w_y1;
        w_a2 = w_steep ? w_y2 : w_x2;
        w_b2 = w_steep ? w_x2 : w_y2;
        w_order     = w_a1 > w_a2;
        n_major     = w_order ? w_a2 : w_a1;
        n_major_end = w_order ? w_a1 : w_a2;
        n_minor     = w_order ? w_b2 : w_b1;
        n_up        = w_order ? (w_b2 < w_b1) : (w_b1 < w_b2);
        w_dmaj      = n_major_end - n_major;
        w_dmin      = w_steep ? w_dx : w_dy;
    end

    // step: emit current pixel, then advance
    logic signed [PW-1:0] w_px, w_py;
    logic [13:0]          w_vp_xlim, w_vp_ylim;
    logic                 w_last, w_vis;
    logic signed [EW-1:0] w_err_add;
    t_pix                 w_pix;

    always_comb begin
        w_px      = r_swap ? r_minor : r_major;
        w_py      = r_swap ? r_major : r_minor;
        w_last    = r_major >= r_major_end;
        w_vp_xlim = {2'b0, r_vp_x} + {1'b0, r_vp_w};
        w_vp_ylim = {2'b0, r_vp_y} + {1'b0, r_vp_h};
        w_vis     = !w_px[PW-1] && !w_py[PW-1]
                 && (w_px < $signed({{(PW-13){1'b0}}, r_win_w}))
                 && (w_py < $signed({{(PW-13){1'b0}}, r_win_h}))
                 && (w_px < $signed({{(PW-14){1'b0}}, w_vp_xlim}))
                 && (w_py < $signed({{(PW-14){1'b0}}, w_vp_ylim}));
        w_pix.x    = w_vis ? w_px[OUT_BITS-1:0] : '0;
        w_pix.y    = w_vis ? w_py[OUT_BITS-1:0] : '0;
        w_pix.vis  = w_vis;
        w_pix.last = w_last;
        // error term tracks offset - threshold, starting at -1
        w_err_add = r_err + $signed({2'b0, r_dmin, 1'b0});
    end

    logic w_take, w_load, w_push, w_pop;
    logic [1:0] r_cnt;
    logic       r_wptr, r_rptr;
    t_pix       r_q [0:1];

    assign w_take = i_cmd.valid && i_cmd.ready;
    assign w_load = w_take && (i_cmd.mode == MODE_LOAD);
    assign w_push = w_take && (i_cmd.mode == MODE_STEP) && r_active;
    assign w_pop  = o_pix.valid && o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major     <= '0;
            r_minor     <= '0;
            r_major_end <= '0;
            r_dmaj      <= '0;
            r_dmin      <= '0;
            r_err       <= -EW'(1);
            r_swap      <= 1'b0;
            r_up        <= 1'b0;
            r_active    <= 1'b0;
        end else if (w_load) begin
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_major_end <= n_major_end;
            r_dmaj      <= w_dmaj[PW-2:0];
            r_dmin      <= w_dmin[PW-2:0];
            r_err       <= -EW'(1);
            r_swap      <= w_steep;
            r_up        <= n_up;
            r_active    <= 1'b1;
        end else if (w_push) begin
            if (!w_err_add[EW-1]) begin
                r_minor <= r_up ? (r_minor + PW'(1)) : (r_minor - PW'(1));
                r_err   <= w_err_add - $signed({2'b0, r_dmaj, 1'b0});
            end else begin
                r_err   <= w_err_add;
            end
            r_major <= r_major + PW'(1);
            if (w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_pix;
        end
    end

    assign i_cmd.ready      = (r_cnt != 2'd2);
    assign o_pix.valid      = (r_cnt != 2'd0);
    assign o_pix.pixel_x    = r_q[r_rptr].x;
    assign o_pix.pixel_y    = r_q[r_rptr].y;
    assign o_pix.visible    = r_q[r_rptr].vis;
    assign o_pix.last_pixel = r_q[r_rptr].last;

endmodule

// File: hw/rtl/lrc_checker.sv
// ----------------------------------------------------------------------------
// lrc_checker: port-level checks for the line rasterizer
// Watches the command and pixel channels over time.
// ----------------------------------------------------------------------------
module lrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_mode,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_out_x,
    input logic [11:0] i_out_y,
    input logic        i_out_vis,
    input logic        i_out_last
);
    import lrc_pkg::*;

    // hold a stalled pixel
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_vis) && $stable(i_out_last))
        else $error("stalled pixel changed");

    // back pressure only while pixels are waiting
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("command blocked with no pixel pending");

    // no pixel appears without a step transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && !(i_in_valid && i_in_ready && (i_in_mode == MODE_STEP))
            |=> !i_out_valid)
        else $error("pixel without step transfer");

    // clipped pixels carry zero coordinates
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_vis |-> (i_out_x == '0) && (i_out_y == '0))
        else $error("clipped pixel has nonzero position");

endmodule

bind line_rasterizer_clipped_top lrc_checker u_lrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_in_mode   (i_cmd.mode),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_x     (o_pix.pixel_x),
    .i_out_y     (o_pix.pixel_y),
    .i_out_vis   (o_pix.visible),
    .i_out_last  (o_pix.last_pixel)
);

// File: bench/line_rasterizer_clipped_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_clipped_top_tb: self-checking bench for the line rasterizer
// Sends load and step commands in random bursts and tracks each line with a
// Bresenham tracker of its own. Every pixel is compared field by field with
// the pixel channel. A short directed opener is followed by random line
// sequences under several register settings, zero and extreme sizes among
// them, while the pixel side stalls on its own pattern.
// ----------------------------------------------------------------------------
module line_rasterizer_clipped_top_tb;
    import lrc_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        logic                 mode;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
    } t_cmd;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    t_cfg_idx                 i_cfg_idx  = CFG_VIEWPORT_X;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    lrc_in_if #(.COORD_BITS(CB)) cmd_if ();
    lrc_out_if                   pix_if ();

    line_rasterizer_clipped_top #(.COORD_BITS(CB)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_pix      (pix_if)
    );

    // register copies
    logic [11:0] vp_x     = '0;
    logic [11:0] vp_y     = '0;
    logic [12:0] vp_w     = SIZE_RESET;
    logic [12:0] vp_h     = SIZE_RESET;
    logic [12:0] win_w    = SIZE_RESET;
    logic [12:0] win_h    = SIZE_RESET;
    logic        pix_mode = 1'b0;

    // line tracker state
    logic signed [24:0] major_at   = '0;
    logic signed [24:0] minor_at   = '0;
    logic signed [24:0] major_stop = '0;
    logic signed [24:0] run_len    = '0;
    logic signed [24:0] rise_len   = '0;
    logic signed [51:0] err_acc    = '0;
    logic signed [51:0] err_limit  = 52'sd1;
    logic               steep      = 1'b0;
    logic               minor_inc  = 1'b0;
    logic               drawing    = 1'b0;

    t_cmd cmd_backlog[$];
    t_pix predicted_pixels[$];
    t_cmd on_bus;

    int error_count   = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int stall_kind    = 0;
    int stall_left    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic note_error(string msg);
        if (error_count < 100) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic longint span(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic longint map_coord(logic signed [CB-1:0] c, logic [12:0] size,
                                         logic [11:0] origin);
        longint cl, sl, ol;
        cl = longint'(c);
        sl = longint'(size);
        ol = longint'(origin);
        if (pix_mode) begin
            return cl + ol;
        end
        return ((cl + 1) * sl + 2 * ol) / 2;
    endfunction

    function automatic longint line_length(t_cmd c);
        longint dx, dy;
        dx = span(map_coord(c.sx, vp_w, vp_x), map_coord(c.ex, vp_w, vp_x));
        dy = span(map_coord(c.sy, vp_h, vp_y), map_coord(c.ey, vp_h, vp_y));
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    // Update the tracked line for one accepted command; a step on an active
    // line yields the pixel the block must emit.
    function automatic void advance_line(t_cmd c);
        longint x1, y1, x2, y2, t;
        longint mj, mn, stop, run, rise, acc, lim;
        longint px, py, ww, wh, lim_x, lim_y;
        logic   last, vis;
        t_pix   p;
        if (c.mode == MODE_LOAD) begin
            x1 = map_coord(c.sx, vp_w, vp_x);
            y1 = map_coord(c.sy, vp_h, vp_y);
            x2 = map_coord(c.ex, vp_w, vp_x);
            y2 = map_coord(c.ey, vp_h, vp_y);
            steep = span(y2, y1) > span(x2, x1);
            if (steep) begin
                t = x1; x1 = y1; y1 = t;
                t = x2; x2 = y2; y2 = t;
            end
            if (x1 > x2) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            major_at   = 25'(x1);
            major_stop = 25'(x2);
            minor_at   = 25'(y1);
            minor_inc  = y1 < y2;
            run_len    = 25'(x2 - x1);
            rise_len   = 25'(span(y2, y1));
            err_acc    = '0;
            err_limit  = 52'sd1;
            drawing    = 1'b1;
        end else if (drawing) begin
            mj    = longint'(major_at);
            mn    = longint'(minor_at);
            stop  = longint'(major_stop);
            run   = longint'(run_len);
            rise  = longint'(rise_len);
            acc   = longint'(err_acc);
            lim   = longint'(err_limit);
            ww    = longint'(win_w);
            wh    = longint'(win_h);
            lim_x = longint'(vp_x) + longint'(vp_w);
            lim_y = longint'(vp_y) + longint'(vp_h);
            px    = steep ? mn : mj;
            py    = steep ? mj : mn;
            last  = mj >= stop;
            // only the upper viewport edges clip
            vis = px >= 0 && py >= 0 && px < ww && py < wh && px < lim_x && py < lim_y;
            p.x    = vis ? px[OUT_BITS-1:0] : '0;
            p.y    = vis ? py[OUT_BITS-1:0] : '0;
            p.vis  = vis;
            p.last = last;
            predicted_pixels = {predicted_pixels, p};
            acc += 2 * rise;
            if (acc >= lim) begin
                mn  += minor_inc ? 1 : -1;
                lim += 2 * run;
            end
            err_acc   = 52'(acc);
            err_limit = 52'(lim);
            minor_at  = 25'(mn);
            major_at  = 25'(mj + 1);
            if (last) begin
                drawing = 1'b0;
            end
        end
    endfunction

    // command driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                advance_line(on_bus);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (gap_left > 0 || cmd_backlog.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    cmd_if.valid <= 1'b0;
                end else begin
                    on_bus = cmd_backlog.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.mode    <= on_bus.mode;
                    cmd_if.start_x <= on_bus.sx;
                    cmd_if.start_y <= on_bus.sy;
                    cmd_if.end_x   <= on_bus.ex;
                    cmd_if.end_y   <= on_bus.ey;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // pixel monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_pix want;
        logic take;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (predicted_pixels.size() == 0) begin
                note_error($sformatf("pixel (%0d,%0d) with none predicted",
                                     pix_if.pixel_x, pix_if.pixel_y));
            end else begin
                want = predicted_pixels.pop_front();
                if (pix_if.pixel_x !== want.x) begin
                    note_error($sformatf("pixel_x %0d, predicted %0d", pix_if.pixel_x, want.x));
                end
                if (pix_if.pixel_y !== want.y) begin
                    note_error($sformatf("pixel_y %0d, predicted %0d", pix_if.pixel_y, want.y));
                end
                if (pix_if.visible !== want.vis) begin
                    note_error($sformatf("visible %0b, predicted %0b", pix_if.visible, want.vis));
                end
                if (pix_if.last_pixel !== want.last) begin
                    note_error($sformatf("last_pixel %0b, predicted %0b",
                                         pix_if.last_pixel, want.last));
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end
        case (stall_kind)
            0, 1:    take = 1'b1;
            2:       take = ($urandom_range(0, 1) == 1);
            default: take = ($urandom_range(0, 3) == 0);
        endcase
        pix_if.ready <= take && (hold_left == 0);
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("line_rasterizer_clipped_top verification failed");
            $finish;
        end
    end

    function automatic void push_cmd(logic mode, int sx, int sy, int ex, int ey);
        t_cmd c;
        c.mode = mode;
        c.sx   = CB'(sx);
        c.sy   = CB'(sy);
        c.ex   = CB'(ex);
        c.ey   = CB'(ey);
        cmd_backlog = {cmd_backlog, c};
    endfunction

    function automatic int nudge_coord(logic signed [CB-1:0] c, int spread);
        int v;
        v = int'(c);
        v = v + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < -(1 << (CB - 1))) begin
            v = -(1 << (CB - 1));
        end
        if (v > (1 << (CB - 1)) - 1) begin
            v = (1 << (CB - 1)) - 1;
        end
        return v;
    endfunction

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_BITS-1:0];
        case (idx)
            CFG_VIEWPORT_X: vp_x     = value[11:0];
            CFG_VIEWPORT_Y: vp_y     = value[11:0];
            CFG_VIEWPORT_W: vp_w     = value[12:0];
            CFG_VIEWPORT_H: vp_h     = value[12:0];
            CFG_WINDOW_W:   win_w    = value[12:0];
            CFG_WINDOW_H:   win_h    = value[12:0];
            CFG_PIXEL_MODE: pix_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned vx, int unsigned vy, int unsigned vw,
                              int unsigned vh, int unsigned ww, int unsigned wh,
                              int unsigned pm);
        write_reg(CFG_VIEWPORT_X, vx);
        write_reg(CFG_VIEWPORT_Y, vy);
        write_reg(CFG_VIEWPORT_W, vw);
        write_reg(CFG_VIEWPORT_H, vh);
        write_reg(CFG_WINDOW_W, ww);
        write_reg(CFG_WINDOW_H, wh);
        write_reg(CFG_PIXEL_MODE, pm);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every command is taken and every pixel has come back, or until
    // DRAIN_LIMIT runs out, then let the last commands settle.
    task automatic wait_idle();
        int n;
        n = 0;
        @(negedge i_clk);
        while (n < DRAIN_LIMIT && (cmd_backlog.size() != 0 || cmd_if.valid ||
                                   predicted_pixels.size() != 0)) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Short lines (up to 48 pixels) run complete and up to two steps past their end;
    // longer lines are cut short by the next load, and some loads are replaced at once.
    task automatic queue_random_lines(int n_items);
        int     done, steps, spread, r;
        longint len;
        t_cmd   ld;
        done = 0;
        while (done < n_items) begin
            r       = $urandom_range(0, 99);
            spread  = $urandom_range(0, 1) ? 3 : 20;
            ld.mode = MODE_LOAD;
            ld.sx   = CB'($urandom);
            ld.sy   = CB'($urandom);
            if (r < 80) begin
                ld.ex = CB'(nudge_coord(ld.sx, spread));
                ld.ey = CB'(nudge_coord(ld.sy, spread));
            end else begin
                ld.ex = CB'($urandom);
                ld.ey = CB'($urandom);
            end
            len = line_length(ld);
            if (r >= 95) begin
                steps = 0;
            end else if (len <= 48) begin
                steps = int'(len) + int'($urandom_range(0, 2));
            end else begin
                steps = $urandom_range(1, 24);
            end
            cmd_backlog = {cmd_backlog, ld};
            repeat (steps) push_cmd(MODE_STEP, $urandom, $urandom, $urandom, $urandom);
            done += 1 + ((steps < len) ? steps : int'(len));
        end
    endtask

    task automatic run_phase(int unsigned vx, int unsigned vy, int unsigned vw,
                             int unsigned vh, int unsigned ww, int unsigned wh,
                             int unsigned pm, int n_items, bit with_hold);
        set_config(vx, vy, vw, vh, ww, wh, pm);
        @(negedge i_clk);
        queue_random_lines(n_items);
        if (with_hold) begin
            hold_requests++;
        end
        wait_idle();
    endtask

    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.mode    = MODE_LOAD;
        cmd_if.start_x = '0;
        cmd_if.start_y = '0;
        cmd_if.end_x   = '0;
        cmd_if.end_y   = '0;
        pix_if.ready   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opener at the register defaults
        @(negedge i_clk);
        push_cmd(MODE_STEP, 0, 0, 0, 0);              // no line yet: dropped
        push_cmd(MODE_LOAD, 0, 0, 0, 0);              // single point at the center
        push_cmd(MODE_STEP, 0, 0, 0, 0);
        push_cmd(MODE_STEP, 0, 0, 0, 0);              // line done: dropped
        push_cmd(MODE_LOAD, -1, -1, -1, -1);          // maps onto the origin
        push_cmd(MODE_STEP, 2047, 2047, -2048, -2048);
        push_cmd(MODE_LOAD, -2048, -2048, 2047, 2047);
        repeat (3) push_cmd(MODE_STEP, -2048, 2047, -2048, 2047);
        push_cmd(MODE_LOAD, 2047, -2048, -2048, 2047);
        push_cmd(MODE_LOAD, 0, -1, 1, -1);            // replaces the line above
        repeat (3) push_cmd(MODE_STEP, 0, 0, 0, 0);
        push_cmd(MODE_LOAD, -1, 0, -1, 1);            // steep line
        repeat (2) push_cmd(MODE_STEP, 0, 0, 0, 0);
        push_cmd(MODE_LOAD, 2047, 2047, 2047, 2047);  // single point far outside
        push_cmd(MODE_STEP, 0, 0, 0, 0);
        wait_idle();

        run_phase(0, 0, 4096, 4096, 4096, 4096, 1, 225, 1'b1);
        run_phase($urandom_range(1, 3000), $urandom_range(1, 3000), $urandom_range(1, 2000),
                  $urandom_range(1, 2000), $urandom_range(1, 4096), $urandom_range(1, 4096),
                  1, 225, 1'b0);
        run_phase($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 12),
                  $urandom_range(0, 12), $urandom_range(1, 4096), $urandom_range(1, 4096),
                  0, 225, 1'b1);
        run_phase(4095, 0, 0, 3, 4096, 1, 0, 225, 1'b0);
        run_phase(4095, 4095, 4096, 4096, 4096, 4096, 1, 225, 1'b0);
        run_phase(0, 0, 2, 2, 4096, 4096, 0, 225, 1'b1);
        run_phase(0, 0, 4096, 0, 1, 1, 1, 100, 1'b0);

        if (predicted_pixels.size() != 0) begin
            note_error($sformatf("%0d predicted pixels never arrived", predicted_pixels.size()));
        end
        if (error_count == 0) begin
            $display("line_rasterizer_clipped_top verification clean");
        end else begin
            $display("line_rasterizer_clipped_top verification failed");
        end
        $finish;
    end

endmodule
